// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL. Empty in synthesis builds.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising edge outside reset
`define QVR_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// Check that a condition never holds outside reset
`define QVR_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define QVR_ASSERT(lbl, clk, rst_n, prop)
`define QVR_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ===== rtl/qvr_pkg.sv =====
`timescale 1ns / 1ps
package qvr_pkg;
    localparam int QVR_QUAT_WIDTH  = 16;
    localparam int QVR_POINT_WIDTH = 32;
    // Sideband flags (sign and valid) carried alongside the divider steps
    typedef struct packed {
        logic neg;
        logic vld;
    } t_div_side;
endpackage

// ===== rtl/qvr_divider.sv =====
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per pipeline stage.
// Requires i_num < i_den * 2^QUOT_W.
module qvr_divider import qvr_pkg::*; #(
    parameter int DEN_W  = 2 * QVR_QUAT_WIDTH + 2,
    parameter int QUOT_W = QVR_POINT_WIDTH + 1
) (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [DEN_W+QUOT_W-1:0]   i_num,
    input  logic [DEN_W-1:0]          i_den,
    input  t_div_side                 i_side,
    output logic [QUOT_W-1:0]         o_quot,
    output t_div_side                 o_side
);
    logic [DEN_W-1:0]  r_rem  [QUOT_W];
    logic [DEN_W-1:0]  r_den  [QUOT_W];
    logic [QUOT_W-1:0] r_low  [QUOT_W];
    logic [QUOT_W-1:0] r_quot [QUOT_W];
    t_div_side         r_side [QUOT_W];

    for (genvar k = 0; k < QUOT_W; k++) begin : g_step
        logic [DEN_W-1:0]  p_rem, p_den, n_rem;
        logic [QUOT_W-1:0] p_low, p_quot, n_low, n_quot;
        t_div_side         p_side;
        logic [DEN_W:0]    trial;
        logic              ge;

        if (k == 0) begin : g_first
            assign p_rem  = i_num[DEN_W+QUOT_W-1:QUOT_W];
            assign p_low  = i_num[QUOT_W-1:0];
            assign p_quot = '0;
            assign p_den  = i_den;
            assign p_side = i_side;
        end else begin : g_next
            assign p_rem  = r_rem[k-1];
            assign p_low  = r_low[k-1];
            assign p_quot = r_quot[k-1];
            assign p_den  = r_den[k-1];
            assign p_side = r_side[k-1];
        end

        // Shift in the next dividend bit and try a subtraction
        always_comb begin
            trial  = {p_rem, p_low[QUOT_W-1]};
            ge     = (trial >= {1'b0, p_den});
            n_rem  = ge ? DEN_W'(trial - {1'b0, p_den}) : trial[DEN_W-1:0];
            n_low  = p_low << 1;
            n_quot = {p_quot[QUOT_W-2:0], ge};
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_low[k]  <= n_low;
                r_quot[k] <= n_quot;
                r_den[k]  <= p_den;
                r_side[k] <= p_side;
            end
        end
    end

    assign o_quot = r_quot[QUOT_W-1];
    assign o_side = r_side[QUOT_W-1];
endmodule

// ===== rtl/quaternion_vector_rotation_core.sv =====
`timescale 1ns / 1ps
// Rotates a Q16.16 point by a Q1.14 quaternion normalised by its squared norm,
// rounding to nearest (ties away from zero) and saturating with an overflow flag.
// A zero quaternion passes the point through with o_zero_quat set. One
// transaction enters per cycle while the output is not stalled; the pipeline depth is
// dominated by the restoring divider that yields one quotient bit per stage. A stall at the
// output freezes the whole pipeline.
`include "assert_macros.svh"
module quaternion_vector_rotation_core import qvr_pkg::*; #(
    parameter int QUAT_WIDTH  = QVR_QUAT_WIDTH,
    parameter int POINT_WIDTH = QVR_POINT_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [QUAT_WIDTH-1:0]  i_quat_x,
    input  logic signed [QUAT_WIDTH-1:0]  i_quat_y,
    input  logic signed [QUAT_WIDTH-1:0]  i_quat_z,
    input  logic signed [QUAT_WIDTH-1:0]  i_quat_w,
    input  logic signed [POINT_WIDTH-1:0] i_point_x,
    input  logic signed [POINT_WIDTH-1:0] i_point_y,
    input  logic signed [POINT_WIDTH-1:0] i_point_z,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [POINT_WIDTH-1:0] o_rot_x,
    output logic signed [POINT_WIDTH-1:0] o_rot_y,
    output logic signed [POINT_WIDTH-1:0] o_rot_z,
    output logic                          o_zero_quat,
    output logic                          o_overflow
);
    localparam int PQ  = 2 * QUAT_WIDTH;        // quaternion product
    localparam int NW  = 2 * QUAT_WIDTH + 1;    // squared norm
    localparam int MW  = 2 * QUAT_WIDTH + 2;    // matrix entry
    localparam int PRW = MW + POINT_WIDTH;      // matrix times point
    localparam int SW  = PRW + 2;               // row sum
    localparam int DW  = 2 * QUAT_WIDTH + 2;    // divisor
    localparam int QB  = POINT_WIDTH + 1;       // quotient
    localparam int AW  = DW + QB;               // dividend
    localparam int PD  = 4 + QB;                // stages ahead of output
    localparam logic [QB-1:0] LIM = QB'(1) << (POINT_WIDTH - 1);

    logic en;
    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    // Sideband pipeline: valid, zero flag and the point
    logic                   r_vld  [PD];
    logic                   r_zero [PD];
    logic [POINT_WIDTH-1:0] r_pt   [PD][3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < PD; k++) r_vld[k] <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < PD; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_zero[0]  <= (i_quat_x == '0) && (i_quat_y == '0) &&
                          (i_quat_z == '0) && (i_quat_w == '0);
            r_pt[0][0] <= i_point_x;
            r_pt[0][1] <= i_point_y;
            r_pt[0][2] <= i_point_z;
            for (int k = 1; k < PD; k++) begin
                r_zero[k] <= r_zero[k-1];
                r_pt[k]   <= r_pt[k-1];
            end
        end
    end

    // Stage 1: quaternion products
    logic signed [PQ-1:0] r_xx, r_yy, r_zz, r_ww, r_xy, r_xz, r_yz, r_wx, r_wy, r_wz;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_xx <= i_quat_x * i_quat_x;
            r_yy <= i_quat_y * i_quat_y;
            r_zz <= i_quat_z * i_quat_z;
            r_ww <= i_quat_w * i_quat_w;
            r_xy <= i_quat_x * i_quat_y;
            r_xz <= i_quat_x * i_quat_z;
            r_yz <= i_quat_y * i_quat_z;
            r_wx <= i_quat_w * i_quat_x;
            r_wy <= i_quat_w * i_quat_y;
            r_wz <= i_quat_w * i_quat_z;
        end
    end

    // Stage 2: rotation matrix and norm
    logic signed [MW-1:0] n_m [3][3];
    logic signed [MW-1:0] r_m [3][3];
    logic signed [MW-1:0] n_norm;
    logic [NW-1:0]        r_norm;
    always_comb begin
        logic signed [MW-1:0] xx, yy, zz, ww, xy, xz, yz, wx, wy, wz;
        xx = MW'(r_xx); yy = MW'(r_yy); zz = MW'(r_zz); ww = MW'(r_ww);
        xy = MW'(r_xy); xz = MW'(r_xz); yz = MW'(r_yz);
        wx = MW'(r_wx); wy = MW'(r_wy); wz = MW'(r_wz);
        n_norm  = ww + xx + yy + zz;
        n_m[0][0] = ww + xx - yy - zz;
        n_m[1][1] = ww + yy - xx - zz;
        n_m[2][2] = ww + zz - xx - yy;
        n_m[0][1] = (xy - wz) <<< 1;
        n_m[0][2] = (xz + wy) <<< 1;
        n_m[1][0] = (xy + wz) <<< 1;
        n_m[1][2] = (yz - wx) <<< 1;
        n_m[2][0] = (xz - wy) <<< 1;
        n_m[2][1] = (yz + wx) <<< 1;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m    <= n_m;
            r_norm <= n_norm[NW-1:0];
        end
    end

    // Stage 3: matrix times point
    logic signed [PRW-1:0] r_prod [3][3];
    logic [NW-1:0]         r_norm3;
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_prod[i][j] <= r_m[i][j] * $signed(r_pt[1][j]);
                end
            end
            r_norm3 <= r_norm;
        end
    end

    // Stage 4: row sums, magnitude and rounding offset
    logic [AW-1:0] r_num [3];
    logic          r_neg [3];
    logic [DW-1:0] r_den;
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                logic signed [SW-1:0] sum;
                logic [SW-1:0]        mag;
                sum = SW'(r_prod[i][0]) + SW'(r_prod[i][1]) + SW'(r_prod[i][2]);
                mag = sum[SW-1] ? SW'(-sum) : SW'(sum);
                r_num[i] <= AW'({mag[AW-2:0], 1'b0}) + AW'(r_norm3);
                r_neg[i] <= sum[SW-1];
            end
            r_den <= {r_norm3, 1'b0};
        end
    end

    // Division lanes
    logic [QB-1:0] quot [3];
    t_div_side     side [3];
    for (genvar i = 0; i < 3; i++) begin : g_lane
        t_div_side lane_side;
        assign lane_side = '{neg: r_neg[i], vld: r_vld[3]};
        qvr_divider #(.DEN_W(DW), .QUOT_W(QB)) u_div (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_num  (r_num[i]),
            .i_den  (r_den),
            .i_side (lane_side),
            .o_quot (quot[i]),
            .o_side (side[i])
        );
    end

    // Output stage: saturate, sign and pass-through
    logic [POINT_WIDTH-1:0] n_rot [3];
    logic                   n_ovf;
    always_comb begin
        n_ovf = 1'b0;
        for (int i = 0; i < 3; i++) begin
            logic [QB-1:0] negq;
            negq = QB'(0) - quot[i];
            if (r_zero[PD-1]) begin
                n_rot[i] = r_pt[PD-1][i];
            end else if (side[i].neg) begin
                if (quot[i] > LIM) begin
                    n_rot[i] = {1'b1, {(POINT_WIDTH-1){1'b0}}};
                    n_ovf    = 1'b1;
                end else begin
                    n_rot[i] = negq[POINT_WIDTH-1:0];
                end
            end else begin
                if (quot[i] >= LIM) begin
                    n_rot[i] = {1'b0, {(POINT_WIDTH-1){1'b1}}};
                    n_ovf    = 1'b1;
                end else begin
                    n_rot[i] = quot[i][POINT_WIDTH-1:0];
                end
            end
        end
        if (r_zero[PD-1]) n_ovf = 1'b0;
    end

    logic r_out_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_vld[PD-1];
        end
    end

    logic [POINT_WIDTH-1:0] r_rot [3];
    logic                   r_zero_out, r_ovf;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rot      <= n_rot;
            r_zero_out <= r_zero[PD-1];
            r_ovf      <= n_ovf;
        end
    end

    assign o_valid     = r_out_vld;
    assign o_rot_x     = r_rot[0];
    assign o_rot_y     = r_rot[1];
    assign o_rot_z     = r_rot[2];
    assign o_zero_quat = r_zero_out;
    assign o_overflow  = r_ovf;

    // Checks
    `QVR_NEVER(a_zero_no_ovf, i_clk, i_rst_n, o_valid && o_zero_quat && o_overflow)
    `QVR_ASSERT(a_div_side_aligned, i_clk, i_rst_n, r_vld[PD-1] |-> side[0].vld)
    `QVR_ASSERT(a_accept_enters, i_clk, i_rst_n, (i_valid && o_ready) |=> r_vld[0])
    `QVR_ASSERT(a_ovf_at_bound, i_clk, i_rst_n, (o_valid && o_overflow) |-> (
        (o_rot_x[POINT_WIDTH-2:0] == '1 || o_rot_x[POINT_WIDTH-2:0] == '0) ||
        (o_rot_y[POINT_WIDTH-2:0] == '1 || o_rot_y[POINT_WIDTH-2:0] == '0) ||
        (o_rot_z[POINT_WIDTH-2:0] == '1 || o_rot_z[POINT_WIDTH-2:0] == '0)))
endmodule
